### rtl/core/lwh_pkg.sv
// Package with shared widths, constants and the exponent root table.
`timescale 1ns / 1ps
package lwh_pkg;
    localparam int LEVEL_FRAC_BITS_DEF = 7;
    localparam int EXP_TABLE_BITS_DEF  = 8;
    localparam int TIME_W  = 27;
    localparam int LEVEL_W = 16;
    localparam logic [26:0] WINDOW_RESET = 27'd60000;
    localparam logic [15:0] LIMIT_RESET  = 16'sd10880;
    localparam logic [24:0] LOG2_10_DIV10_Q24 = 25'd5573271;
    localparam logic [26:0] TEN_LOG10_2_Q24   = 27'd50504453;
    localparam logic [2:0] ADDR_WINDOW = 3'd0;
    localparam logic [2:0] ADDR_LIMIT  = 3'd4;

    // 2^(2^-k) in Q30 for k = 1..12.
    function automatic logic [31:0] root_q30(input int k);
        case (k)
            1:  root_q30 = 32'd1518500250;
            2:  root_q30 = 32'd1276901417;
            3:  root_q30 = 32'd1170923762;
            4:  root_q30 = 32'd1121280436;
            5:  root_q30 = 32'd1097253708;
            6:  root_q30 = 32'd1085434106;
            7:  root_q30 = 32'd1079572136;
            8:  root_q30 = 32'd1076653033;
            9:  root_q30 = 32'd1075196444;
            10: root_q30 = 32'd1074468888;
            11: root_q30 = 32'd1074105294;
            12: root_q30 = 32'd1073923544;
            default: root_q30 = 32'd1073741824;
        endcase
    endfunction
endpackage

### rtl/core/leq_window_headroom.sv
// Top level of the Leq window headroom pipeline.
//
// Channel  | Direction | Transfer
// s_axis   | in        | tdata[26:0] elapsed_ms, tdata[42:27] elapsed_level
// m_axis   | out       | tdata[15:0] headroom_level, tuser headroom_valid
// apb      | in        | 0x0 window_ms, 0x4 limit_level
//
// One item enters per cycle while m_axis does not stall; the stages are one
// capture stage, one multiplier stage per exponent bit, product, shift and
// normalization stages, one squaring stage per log fraction bit (two log units
// run side by side), a log difference stage and a scaling stage.
// aresetn clears the valid bits and registers; data stages carry no reset.
// A stall on m_axis holds every stage at once, so nothing is lost or repeated.
`timescale 1ns / 1ps
module leq_window_headroom #(
    parameter int LEVEL_FRAC_BITS = lwh_pkg::LEVEL_FRAC_BITS_DEF,
    parameter int EXP_TABLE_BITS  = lwh_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [26:0] elapsed_ms, [42:27] elapsed_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] headroom_level
    output logic        m_axis_tuser,   // [0] headroom_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lwh_pkg::*;

    localparam int SX = 24 + LEVEL_FRAC_BITS - EXP_TABLE_BITS;
    localparam int ST = 40 - LEVEL_FRAC_BITS;
    localparam int EB = EXP_TABLE_BITS;
    localparam int NS = 4 + EB + 16 + 2;

    // Configuration registers.
    logic [26:0] window_reg;
    logic signed [15:0] limit_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_WINDOW) window_reg <= pwdata[26:0];
            if (paddr == ADDR_LIMIT)  limit_reg  <= pwdata[15:0];
        end
    end
    always_comb begin
        case (paddr)
            ADDR_WINDOW: prdata = {5'd0, window_reg};
            ADDR_LIMIT:  prdata = {{16{limit_reg[15]}}, limit_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Pipeline advance: stall everything when the output holds an untaken result.
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    typedef struct packed {
        logic        fin;      // result settled early
        logic        ok;
        logic signed [15:0] res;
        logic signed [15:0] lim;
        logic [26:0] w;
        logic [26:0] e;
        logic signed [47:0] x;
        logic [30:0] m;
        logic [59:0] t;
        logic [56:0] num;
        logic [26:0] rem;
        logic [5:0]  ea;
        logic [31:0] ya;
        logic [15:0] fa;
        logic [4:0]  eb;
        logic [31:0] yb;
        logic [15:0] fb;
        logic signed [47:0] dl;
    } stg_t;

    stg_t st_reg [NS];
    logic vld_reg [NS];
    stg_t st_next [NS];

    // Stage 0: capture, special cases, d*log2(10)/10.
    always_comb begin
        logic [26:0] e;
        logic signed [16:0] d;
        logic signed [47:0] p;
        st_next[0] = '0;
        e = s_axis_tdata[26:0];
        st_next[0].w = window_reg;
        st_next[0].e = e;
        st_next[0].lim = limit_reg;
        d = $signed({s_axis_tdata[42], s_axis_tdata[42:27]}) -
            $signed({limit_reg[15], limit_reg});
        p = 48'(d) * $signed({23'd0, LOG2_10_DIV10_Q24}) +
            (48'sd1 <<< (SX - 1));
        st_next[0].x = p >>> SX;
        if (window_reg == 27'd0 || e >= window_reg) begin
            st_next[0].fin = 1'b1;
        end else if (e == 27'd0) begin
            st_next[0].fin = 1'b1;
            st_next[0].ok = 1'b1;
            st_next[0].res = limit_reg;
        end
        st_next[0].m = 31'h4000_0000;
    end

    // Stages 1..EB: one root multiply per fraction bit.
    for (genvar b = 0; b < EB; b++) begin : g_exp
        always_comb begin
            logic [62:0] pr;
            st_next[b+1] = st_reg[b];
            pr = 63'(st_reg[b].m) * 63'(root_q30(EB - b)) + (63'd1 << 29);
            if (st_reg[b].x[b] && (EB - b) <= 12) st_next[b+1].m = 31'(pr >> 30);
        end
    end

    // Stage EB+1: T = E*m.
    always_comb begin
        st_next[EB+1] = st_reg[EB];
        st_next[EB+1].t = 60'(st_reg[EB].e) * 60'(st_reg[EB].m);
    end

    // Stage EB+2: shift by the integer part, form num and W-E.
    always_comb begin
        stg_t s;
        logic signed [47:0] ip;
        logic [59:0] wq, t;
        s = st_reg[EB+1];
        st_next[EB+2] = s;
        ip = s.x >>> EB;
        wq = {s.w, 30'd0} & 60'h0FFF_FFFF_FFFF_FFF;
        wq = 60'(s.w) << 30;
        t = s.t;
        if (!s.fin) begin
            if (ip >= 48'sd30) begin
                st_next[EB+2].fin = 1'b1;
            end else if (ip >= 0) begin
                if (t > (wq >> ip[4:0])) st_next[EB+2].fin = 1'b1;
                t = t << ip[4:0];
            end else begin
                t = (-ip >= 48'sd64) ? 60'd0 : (t >> (-ip));
            end
            if (t >= wq) st_next[EB+2].fin = 1'b1;
        end
        st_next[EB+2].num = 57'(wq - t);
        st_next[EB+2].rem = s.w - s.e;
    end

    // Stage EB+3: msb search and normalization for both logs.
    always_comb begin
        stg_t s;
        s = st_reg[EB+2];
        st_next[EB+3] = s;
        st_next[EB+3].ea = '0;
        st_next[EB+3].eb = '0;
        for (int i = 0; i < 57; i++) if (s.num[i]) st_next[EB+3].ea = 6'(i);
        for (int i = 0; i < 27; i++) if (s.rem[i]) st_next[EB+3].eb = 5'(i);
        if (st_next[EB+3].ea >= 30)
            st_next[EB+3].ya = 32'(s.num >> (st_next[EB+3].ea - 6'd30));
        else
            st_next[EB+3].ya = 32'(s.num << (6'd30 - st_next[EB+3].ea));
        st_next[EB+3].yb = 32'(57'(s.rem) << (5'd30 - st_next[EB+3].eb));
        st_next[EB+3].fa = '0;
        st_next[EB+3].fb = '0;
    end

    // Stages EB+4..EB+19: one squaring per fraction bit.
    for (genvar n = 0; n < 16; n++) begin : g_log
        always_comb begin
            stg_t s;
            logic [63:0] qa, qb;
            s = st_reg[EB+3+n];
            st_next[EB+4+n] = s;
            qa = (64'(s.ya) * 64'(s.ya)) >> 30;
            qb = (64'(s.yb) * 64'(s.yb)) >> 30;
            st_next[EB+4+n].fa = {s.fa[14:0], qa[31]};
            st_next[EB+4+n].fb = {s.fb[14:0], qb[31]};
            st_next[EB+4+n].ya = qa[31] ? 32'(qa >> 1) : 32'(qa);
            st_next[EB+4+n].yb = qb[31] ? 32'(qb >> 1) : 32'(qb);
        end
    end

    // Stage EB+20: log difference.
    always_comb begin
        stg_t s;
        s = st_reg[EB+19];
        st_next[EB+20] = s;
        st_next[EB+20].dl = $signed(48'({s.ea, s.fa})) - (48'sd30 <<< 16) -
                            $signed(48'({s.eb, s.fb}));
    end

    // Stage EB+21: scale to dB, add limit, saturate.
    // The log difference stays within 23 signed bits, so a narrow product serves.
    always_comb begin
        stg_t s;
        logic signed [23:0] dn;
        logic signed [51:0] p;
        logic signed [51:0] r;
        s = st_reg[EB+20];
        st_next[EB+21] = s;
        dn = s.dl[23:0];
        p = 52'(dn) * $signed({25'd0, TEN_LOG10_2_Q24}) + (52'sd1 <<< (ST - 1));
        r = (p >>> ST) + 52'(s.lim);
        if (!s.fin) begin
            st_next[EB+21].ok = 1'b1;
            if (r > 52'sd32767) st_next[EB+21].res = 16'sh7FFF;
            else if (r < -52'sd32768) st_next[EB+21].res = 16'sh8000;
            else st_next[EB+21].res = r[15:0];
        end
    end

    // Stage registers with valid bits.
    for (genvar k = 0; k < NS; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= (k == 0) ? s_axis_tvalid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) st_reg[k] <= st_next[k];
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = st_reg[NS-1].ok ? st_reg[NS-1].res : 16'd0;
    assign m_axis_tuser  = st_reg[NS-1].ok;
endmodule

### test/leq_window_headroom_test.sv
// Testbench for the Leq window headroom block: directed table, random items, predictor checks.
`timescale 1ns / 1ps
module leq_window_headroom_test;
    import lwh_pkg::*;

    localparam int LATENCY = EXP_TABLE_BITS_DEF + 22;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [26:0] TIME_MAX = 27'h7FFFFFF;

    typedef struct packed {
        logic signed [15:0] level;
        logic               ok;
    } headroom_t;

    // One row of the directed table: either a register write or an input item.
    typedef struct {
        bit          is_reg;
        logic [2:0]  addr;
        logic [31:0] wval;
        logic [26:0] elapsed;
        logic [15:0] level;
        bit          typed;
        headroom_t   want;
    } row_t;

    // Q30 values of 2^(2^-k), k = 1..8.
    localparam longint unsigned ROOTS[8] = '{
        64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
        64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    leq_window_headroom uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [26:0]        window_cfg = WINDOW_RESET;
    logic signed [15:0] limit_cfg  = LIMIT_RESET;
    headroom_t          pending[$];
    bit                 typed_q[$];
    headroom_t          typed_val_q[$];
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 n_items = 0;
    int                 n_valid = 0;
    bit                 gaps_on = 1'b1;
    bit                 hold_long = 1'b0;
    row_t               rows[$];

    // log2 of a positive integer in Q16, fraction bits by repeated squaring.
    function automatic longint log2_q16(input longint unsigned v);
        int e;
        longint unsigned y;
        longint unsigned fr;
        e = 63;
        fr = 0;
        if (v == 0) return 0;
        while (v[e] == 1'b0) e--;
        y = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int n = 0; n < 16; n++) begin
            y = (y * y) >> 30;
            fr = fr << 1;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(e) << 16) | longint'(fr);
    endfunction

    // Headroom level from the current window and limit registers.
    function automatic headroom_t headroom_of(input logic [26:0] e_in,
                                             input logic signed [15:0] le);
        longint unsigned w, e, m, t, wq, num;
        longint d, x, ip, dl, delta, res;
        logic [7:0] f;
        headroom_t r;
        r = '0;
        w = window_cfg;
        e = e_in;
        if (w == 0 || e >= w) return r;
        if (e == 0) begin
            res = limit_cfg;
        end else begin
            d = longint'(le) - longint'(limit_cfg);
            x = (d * 64'sd5573271 + (64'sd1 <<< 22)) >>> 23;
            ip = x >>> 8;
            f = x[7:0];
            m = 64'd1 << 30;
            for (int b = 0; b < 8; b++)
                if (f[b]) m = (m * ROOTS[7 - b] + (64'd1 << 29)) >> 30;
            t = e * m;
            wq = w << 30;
            if (ip >= 30) return r;
            if (ip >= 0) begin
                if (t > (wq >> ip)) return r;
                t = t << ip;
            end else begin
                t = (-ip >= 64) ? 0 : (t >> (-ip));
            end
            if (t >= wq) return r;
            num = wq - t;
            dl = log2_q16(num) - (64'sd30 <<< 16) - log2_q16(w - e);
            delta = (dl * 64'sd50504453 + (64'sd1 <<< 32)) >>> 33;
            res = longint'(limit_cfg) + delta;
        end
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        r.level = res[15:0];
        r.ok = 1'b1;
        return r;
    endfunction

    // Input transfers produce expectations; output transfers are checked in order.
    always @(posedge aclk) begin
        headroom_t want, got, typed_want;
        bit is_typed;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            want = headroom_of(s_axis_tdata[26:0], $signed(s_axis_tdata[42:27]));
            is_typed = typed_q.pop_front();
            typed_want = typed_val_q.pop_front();
            if (is_typed) want = typed_want;
            pending.push_back(want);
            n_items++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.level = m_axis_tdata;
            got.ok = m_axis_tuser;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: level %0d valid %0d",
                                               got.level, got.ok);
            end else begin
                want = pending.pop_front();
                if (got.ok) n_valid++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want level %0d valid %0d, got level %0d valid %0d",
                                 want.level, want.ok, got.level, got.ok);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("leq_window_headroom_test: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_long = 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WINDOW) window_cfg = val[26:0];
        else limit_cfg = val[15:0];
    endtask

    // Wait for the pipeline to drain before touching registers.
    task automatic wait_idle();
        while (pending.size() != 0 || typed_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic send(input logic [26:0] e, input logic [15:0] le,
                        input bit typed, input headroom_t want);
        typed_q.push_back(typed);
        typed_val_q.push_back(want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, le, e};
        do @(posedge aclk); while (!s_axis_tready);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    function automatic row_t item(input logic [26:0] e, input logic [15:0] le,
                                  input bit typed, input logic signed [15:0] lvl,
                                  input logic ok);
        row_t r;
        r = '{default: '0};
        r.elapsed = e;
        r.level = le;
        r.typed = typed;
        r.want.level = lvl;
        r.want.ok = ok;
        return r;
    endfunction

    function automatic row_t wreg(input logic [2:0] addr, input logic [31:0] val);
        row_t r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.addr = addr;
        r.wval = val;
        return r;
    endfunction

    task automatic random_item();
        logic [26:0] e;
        logic [15:0] le;
        headroom_t none;
        none = '0;
        case ($urandom_range(0, 9))
            0: e = '0;
            1: e = 27'($urandom);
            2: e = (window_cfg > TIME_MAX - 27'd100) ? TIME_MAX :
                   window_cfg + 27'($urandom_range(0, 99));
            default: e = (window_cfg > 1) ?
                         27'($urandom_range(1, window_cfg - 1)) : 27'd0;
        endcase
        if ($urandom_range(0, 9) < 7) begin
            int v;
            v = int'(limit_cfg) + $signed($urandom_range(0, 3000)) - 1500;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            le = v[15:0];
        end else begin
            le = 16'($urandom);
        end
        send(e, le, 1'b0, none);
    endtask

    initial begin
        rows.push_back(item(0, 0, 1, 10880, 1));
        rows.push_back(item(0, 16'h8000, 1, 10880, 1));
        rows.push_back(item(60000, 10880, 1, 0, 0));
        rows.push_back(item(TIME_MAX, 16'h7FFF, 1, 0, 0));
        rows.push_back(item(30000, 16'h7FFF, 1, 0, 0));
        rows.push_back(item(1, 16'h7FFF, 1, 0, 0));
        rows.push_back(item(30000, 10880, 0, 0, 0));
        rows.push_back(item(1, 16'h8000, 0, 0, 0));
        rows.push_back(item(59999, 16'h8000, 0, 0, 0));
        rows.push_back(item(59999, 10880, 0, 0, 0));
        rows.push_back(item(20000, 9000, 0, 0, 0));
        rows.push_back(wreg(ADDR_WINDOW, 0));
        rows.push_back(item(0, 0, 1, 0, 0));
        rows.push_back(item(TIME_MAX, 16'h8000, 1, 0, 0));
        rows.push_back(wreg(ADDR_WINDOW, 1));
        rows.push_back(wreg(ADDR_LIMIT, 32'hFFFF8000));
        rows.push_back(item(0, 16'h7FFF, 1, -32768, 1));
        rows.push_back(item(1, 16'h8000, 1, 0, 0));
        rows.push_back(wreg(ADDR_WINDOW, TIME_MAX));
        rows.push_back(wreg(ADDR_LIMIT, 32'h7FFF));
        rows.push_back(item(0, 16'h8000, 1, 32767, 1));
        rows.push_back(item(1, 16'h8000, 0, 0, 0));
        rows.push_back(item(TIME_MAX - 1, 16'h8000, 0, 0, 0));
        rows.push_back(item(TIME_MAX, 0, 1, 0, 0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; registers are only written with the pipeline empty.
        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                s_axis_tvalid <= 1'b0;
                wait_idle();
                reg_write(rows[i].addr, rows[i].wval);
            end else begin
                send(rows[i].elapsed, rows[i].level, rows[i].typed, rows[i].want);
            end
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            s_axis_tvalid <= 1'b0;
            wait_idle();
            case (ph)
                0: begin
                    reg_write(ADDR_WINDOW, $urandom_range(1000, 86400000));
                    reg_write(ADDR_LIMIT, $urandom);
                end
                1: begin
                    reg_write(ADDR_WINDOW, 2);
                    reg_write(ADDR_LIMIT, 10880);
                end
                2: begin
                    reg_write(ADDR_WINDOW, 86400000);
                    reg_write(ADDR_LIMIT, 0);
                end
                3: begin
                    reg_write(ADDR_WINDOW, $urandom);
                    reg_write(ADDR_LIMIT, $urandom_range(0, 20000));
                end
                4: begin
                    reg_write(ADDR_WINDOW, 60000);
                    reg_write(ADDR_LIMIT, $urandom);
                end
                default: begin
                    gaps_on = 1'b0;
                    reg_write(ADDR_WINDOW, $urandom_range(1, 1000000));
                    reg_write(ADDR_LIMIT, $urandom_range(5000, 15000));
                end
            endcase
            for (int k = 0; k < 125; k++) begin
                if (ph == 2 && k == 20) hold_long = 1'b1;
                if (ph == 3 && k == 60) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending.size() != 0 || typed_q.size() != 0) @(posedge aclk);
                end
                random_item();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        mismatches += pending.size();
        $display("Covered %0d input transfers over the directed table and six random",
                 n_items);
        $display("register settings, %0d valid results, with stall bursts, a long", n_valid);
        $display("output hold-off and a full drain pause.");
        if (mismatches == 0) begin
            $display("leq_window_headroom_test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("leq_window_headroom_test: errors");
        end
        $finish;
    end
endmodule
